// ===== rtl/sbt_pkg.sv =====
// Shared types, constants and helpers for the source byte tokenizer.
package sbt_pkg;

  localparam longint unsigned MAX_TEXT_BYTES = 64'd65536;
  localparam logic [15:0] POS_CAP = ((MAX_TEXT_BYTES - 64'd1) > 64'd65535) ?
                                    16'hFFFF : 16'(MAX_TEXT_BYTES - 64'd1);
  localparam int unsigned KW_CHARS = 6;

  localparam logic [4:0] CLS_INVALID = 5'd0;
  localparam logic [4:0] CLS_EOP     = 5'd1;
  localparam logic [4:0] CLS_DEC     = 5'd2;
  localparam logic [4:0] CLS_HEX     = 5'd3;
  localparam logic [4:0] CLS_BIN     = 5'd4;
  localparam logic [4:0] CLS_IDENT   = 5'd5;
  localparam logic [4:0] CLS_FN      = 5'd6;
  localparam logic [4:0] CLS_G8      = 5'd7;
  localparam logic [4:0] CLS_G16     = 5'd8;
  localparam logic [4:0] CLS_G32     = 5'd9;
  localparam logic [4:0] CLS_G64     = 5'd10;
  localparam logic [4:0] CLS_PACK    = 5'd11;
  localparam logic [4:0] CLS_RETURN  = 5'd12;
  localparam logic [4:0] CLS_SEMI    = 5'd13;
  localparam logic [4:0] CLS_LBRACE  = 5'd14;
  localparam logic [4:0] CLS_RBRACE  = 5'd15;
  localparam logic [4:0] CLS_LPAREN  = 5'd16;
  localparam logic [4:0] CLS_RPAREN  = 5'd17;
  localparam logic [4:0] CLS_ASSIGN  = 5'd18;
  localparam logic [4:0] CLS_PLUS    = 5'd19;
  localparam logic [4:0] CLS_MINUS   = 5'd20;
  localparam logic [4:0] CLS_STAR    = 5'd21;
  localparam logic [4:0] CLS_SLASH   = 5'd22;
  localparam logic [4:0] CLS_NEWLINE = 5'd23;
  localparam logic [4:0] CLS_NUM_ERR = 5'd24;
  localparam logic [4:0] CLS_BIN_ERR = 5'd25;

  localparam logic [15:0] KW_FN     = "fn";
  localparam logic [15:0] KW_G8     = "g8";
  localparam logic [23:0] KW_G16    = "g16";
  localparam logic [23:0] KW_G32    = "g32";
  localparam logic [23:0] KW_G64    = "g64";
  localparam logic [31:0] KW_PACK   = "pack";
  localparam logic [47:0] KW_RETURN = "return";

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_DEC,
    MODE_HEX,
    MODE_BIN,
    MODE_WORD,
    MODE_DISCARD
  } scan_mode_e;

  typedef logic [KW_CHARS-1:0][7:0] kw_prefix_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } tok_in_t;

  typedef struct packed {
    logic [4:0]  token_class;
    logic [15:0] token_offset;
    logic [15:0] token_size;
    logic [15:0] source_line;
    logic        last_of_run;
  } tok_out_t;

  function automatic logic [15:0] sat_pos(logic [15:0] p);
    return (p < POS_CAP) ? p + 16'd1 : POS_CAP;
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [4:0] word_class(logic [15:0] len, kw_prefix_t pfx);
    logic [4:0] cls;
    cls = CLS_IDENT;
    case (len)
      16'd2: begin
        if ({pfx[0], pfx[1]} == KW_FN) cls = CLS_FN;
        else if ({pfx[0], pfx[1]} == KW_G8) cls = CLS_G8;
      end
      16'd3: begin
        if ({pfx[0], pfx[1], pfx[2]} == KW_G16) cls = CLS_G16;
        else if ({pfx[0], pfx[1], pfx[2]} == KW_G32) cls = CLS_G32;
        else if ({pfx[0], pfx[1], pfx[2]} == KW_G64) cls = CLS_G64;
      end
      16'd4: begin
        if ({pfx[0], pfx[1], pfx[2], pfx[3]} == KW_PACK) cls = CLS_PACK;
      end
      16'd6: begin
        if ({pfx[0], pfx[1], pfx[2], pfx[3], pfx[4], pfx[5]} == KW_RETURN) cls = CLS_RETURN;
      end
      default: cls = CLS_IDENT;
    endcase
    return cls;
  endfunction

  function automatic logic [4:0] punct_class(logic [7:0] c);
    logic [4:0] cls;
    case (c)
      ";":     cls = CLS_SEMI;
      "{":     cls = CLS_LBRACE;
      "}":     cls = CLS_RBRACE;
      "(":     cls = CLS_LPAREN;
      ")":     cls = CLS_RPAREN;
      "=":     cls = CLS_ASSIGN;
      "+":     cls = CLS_PLUS;
      "-":     cls = CLS_MINUS;
      "*":     cls = CLS_STAR;
      "/":     cls = CLS_SLASH;
      default: cls = CLS_INVALID;
    endcase
    return cls;
  endfunction

  function automatic logic is_pending(scan_mode_e m);
    return (m == MODE_ZERO) || (m == MODE_DEC) || (m == MODE_HEX) ||
           (m == MODE_BIN) || (m == MODE_WORD);
  endfunction

  function automatic logic [4:0] pending_class(scan_mode_e m, logic [4:0] wcls);
    logic [4:0] cls;
    case (m)
      MODE_ZERO, MODE_DEC: cls = CLS_DEC;
      MODE_HEX:            cls = CLS_HEX;
      MODE_BIN:            cls = CLS_BIN;
      MODE_WORD:           cls = wcls;
      default:             cls = CLS_INVALID;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/sbt_stream_if.sv =====
// Valid/ready stream interfaces for source bytes and tokens.
interface sbt_byte_if;
  logic            valid;
  logic            ready;
  sbt_pkg::tok_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sbt_token_if;
  logic              valid;
  logic              ready;
  sbt_pkg::tok_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/source_byte_tokenizer_unit.sv =====
// Streaming tokenizer: source bytes in, classified tokens out.
// The first token of a byte is presented in the cycle after its transaction.
// Throughput: one byte per cycle with a ready sink; a byte that yields n tokens
// (n up to 3) fills the three-entry output register, which drains one token a cycle.
// Reset: asynchronous, active low; scanner returns to idle at offset 0, line 1,
// and the output register empties. State also restarts after a byte with the end flag.
module source_byte_tokenizer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  sbt_byte_if.sink    byte_i,
  sbt_token_if.source token_o
);
  import sbt_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] start_q, start_d;
  logic [15:0] len_q, len_d;
  logic [15:0] line_q, line_d;
  kw_prefix_t  prefix_q, prefix_d;

  tok_out_t    res_q [3];
  tok_out_t    res_d [3];
  logic [1:0]  cnt_q, cnt_d;

  logic [7:0]  b;
  logic        last;
  logic        dig, let_c, accept, pop;
  logic        do_close, do_idle, do_fail;
  logic [4:0]  fail_cls;
  logic [4:0]  wcls_q;

  tok_out_t    cand [4];
  logic [3:0]  cand_v;
  tok_out_t    list [3];
  logic [1:0]  n;

  assign b      = byte_i.payload.text_byte;
  assign last   = byte_i.payload.end_of_text;
  assign dig    = is_digit(b);
  assign let_c  = is_letter(b);
  assign accept = byte_i.valid & byte_i.ready;
  assign pop    = token_o.valid & token_o.ready;

  assign byte_i.ready    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && token_o.ready);
  assign token_o.valid   = (cnt_q != 2'd0);
  assign token_o.payload = res_q[0];

  assign wcls_q = word_class(len_q, prefix_q);

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    do_close = 1'b0;
    do_idle  = 1'b0;
    do_fail  = 1'b0;
    fail_cls = CLS_NUM_ERR;
    cand_v   = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    // slot 0: close old pending
    cand[0].token_class  = pending_class(mode_q, wcls_q);
    cand[0].token_offset = start_q;
    cand[0].token_size   = len_q;
    cand[0].source_line  = line_q;
    // slot 1: token of this byte
    cand[1].token_offset = pos_q;
    cand[1].token_size   = 16'd1;
    cand[1].source_line  = line_q;

    if (mode_q != MODE_DISCARD) begin
      pos_d = sat_pos(pos_q);
      if (b == 8'd0) begin
        cand_v[0] = is_pending(mode_q);
        cand_v[3] = 1'b1;
        cand[3].token_class  = CLS_EOP;
        cand[3].token_offset = pos_q;
        cand[3].token_size   = 16'd0;
        cand[3].source_line  = line_q;
        mode_d = MODE_DISCARD;
      end else begin
        case (mode_q)
          MODE_ZERO: begin
            if (b == "x" || b == "b") begin
              mode_d  = (b == "x") ? MODE_HEX : MODE_BIN;
              start_d = sat_pos(pos_q);
              len_d   = 16'd0;
            end else if (dig) begin
              mode_d = MODE_DEC;
              len_d  = sat16(len_q);
            end else if (let_c) begin
              do_fail = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          MODE_DEC: begin
            if (dig) len_d = sat16(len_q);
            else if (let_c) do_fail = 1'b1;
            else do_close = 1'b1;
          end
          MODE_HEX: begin
            if (dig || let_c) len_d = sat16(len_q);
            else do_close = 1'b1;
          end
          MODE_BIN: begin
            if (b == "0" || b == "1") begin
              len_d = sat16(len_q);
            end else if (dig || let_c) begin
              do_fail  = 1'b1;
              fail_cls = CLS_BIN_ERR;
            end else begin
              do_close = 1'b1;
            end
          end
          MODE_WORD: begin
            if (dig || let_c || b == "_") begin
              for (int i = 0; i < KW_CHARS; i++) begin
                if (len_q == 16'(i)) prefix_d[i] = b;
              end
              len_d = sat16(len_q);
            end else begin
              do_close = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        if (do_close) begin
          cand_v[0] = 1'b1;
          mode_d    = MODE_IDLE;
          do_idle   = 1'b1;
        end

        if (do_fail) begin
          cand_v[1] = 1'b1;
          cand[1].token_class = fail_cls;
          mode_d = MODE_DISCARD;
        end

        if (do_idle) begin
          if (b == " " || b == "\t" || b == "\r") begin
            mode_d = MODE_IDLE;
          end else if (b == "0" || dig) begin
            mode_d   = (b == "0") ? MODE_ZERO : MODE_DEC;
            start_d  = pos_q;
            len_d    = 16'd1;
            prefix_d = '0;
          end else if (let_c || b == "_") begin
            mode_d      = MODE_WORD;
            start_d     = pos_q;
            len_d       = 16'd1;
            prefix_d    = '0;
            prefix_d[0] = b;
          end else if (b == "\n") begin
            cand_v[1] = 1'b1;
            cand[1].token_class = CLS_NEWLINE;
            line_d = sat16(line_q);
          end else begin
            cand_v[1] = 1'b1;
            cand[1].token_class = punct_class(b);
          end
        end

        if (last && mode_d != MODE_DISCARD) begin
          cand_v[2] = is_pending(mode_d);
          cand[2].token_class  = pending_class(mode_d, word_class(len_d, prefix_d));
          cand[2].token_offset = start_d;
          cand[2].token_size   = len_d;
          cand[2].source_line  = line_d;
          cand_v[3] = 1'b1;
          cand[3].token_class  = CLS_EOP;
          cand[3].token_offset = pos_d;
          cand[3].token_size   = 16'd0;
          cand[3].source_line  = line_d;
        end
      end
    end

    if (last) begin
      mode_d   = MODE_IDLE;
      pos_d    = 16'd0;
      start_d  = 16'd0;
      len_d    = 16'd0;
      line_d   = 16'd1;
      prefix_d = '0;
    end
  end

  always_comb begin
    n = 2'd0;
    for (int j = 0; j < 3; j++) begin
      list[j] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n != 2'd3) begin
        list[n] = cand[i];
        n = n + 2'd1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      list[j].last_of_run = (n == 2'(j + 1));
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int j = 0; j < 3; j++) begin
      res_d[j] = res_q[j];
    end
    if (accept) begin
      cnt_d = n;
      for (int j = 0; j < 3; j++) begin
        res_d[j] = list[j];
      end
    end else if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= 16'd0;
      start_q  <= 16'd0;
      len_q    <= 16'd0;
      line_q   <= 16'd1;
      prefix_q <= '0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        mode_q   <= mode_d;
        pos_q    <= pos_d;
        start_q  <= start_d;
        len_q    <= len_d;
        line_q   <= line_d;
        prefix_q <= prefix_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      res_q[j] <= res_d[j];
    end
  end

endmodule
